// File: rtl/assert_macros.svh
// Assertion helpers used by the comfort noise generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/scng_pkg.sv
package scng_pkg;

  localparam int PW = 48;   // power word, Q40.8
  localparam int CW = 25;   // coefficient word, Q24
  localparam int MW = 24;   // magnitude, Q20.4
  localparam int OW = 26;   // noise output, Q21.4
  localparam int SW = 31;   // LCG state

  localparam logic [PW-1:0] NOISE_RESET = 48'd256000000;
  localparam logic [PW-1:0] FLOOR_RESET = 48'd4385;

  localparam logic [CW-1:0] C_SM_OLD = 25'd15099494;
  localparam logic [CW-1:0] C_SM_NEW = 25'd1677722;
  localparam logic [CW-1:0] C_N2_SM  = 25'd15102514;
  localparam logic [CW-1:0] C_N2_OLD = 25'd1678057;
  localparam logic [CW-1:0] C_N2_UP  = 25'd16780571;
  localparam logic [CW-1:0] C_IN_OLD = 25'd16760439;
  localparam logic [CW-1:0] C_IN_NEW = 25'd16777;

  localparam logic [16:0]   LCG_MUL        = 17'd69069;
  localparam logic [SW-1:0] LCG_SEED_RESET = 31'd42;

  localparam logic [9:0] FRAME_ADAPT      = 10'd50;
  localparam logic [9:0] FRAME_ADAPT_LATE = 10'd51;
  localparam logic [9:0] INIT_FRAMES      = 10'd1000;

  localparam logic signed [15:0] SIN_TAB [32] = '{
    16'sd0, 16'sd4520, 16'sd8867, 16'sd12873, 16'sd16384, 16'sd19266, 16'sd21407,
    16'sd22725, 16'sd23170, 16'sd22725, 16'sd21407, 16'sd19266, 16'sd16384,
    16'sd12873, 16'sd8867, 16'sd4520, 16'sd0, -16'sd4520, -16'sd8867, -16'sd12873,
    -16'sd16384, -16'sd19266, -16'sd21407, -16'sd22725, -16'sd23170, -16'sd22725,
    -16'sd21407, -16'sd19266, -16'sd16384, -16'sd12873, -16'sd8867, -16'sd4520};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_MUL_GO, S_MUL_WAIT, S_FLOOR, S_IFLOOR,
    S_WRITE, S_SQRT_WAIT, S_SCALE_RE, S_SCALE_IM, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_SM_OLD, OP_SM_NEW, OP_N2_SM, OP_N2_OLD, OP_N2_UP, OP_IN_OLD, OP_IN_NEW
  } mul_op_t;

  function automatic logic [CW-1:0] coef(mul_op_t op);
    case (op)
      OP_SM_OLD: coef = C_SM_OLD;
      OP_SM_NEW: coef = C_SM_NEW;
      OP_N2_SM:  coef = C_N2_SM;
      OP_N2_OLD: coef = C_N2_OLD;
      OP_N2_UP:  coef = C_N2_UP;
      OP_IN_OLD: coef = C_IN_OLD;
      OP_IN_NEW: coef = C_IN_NEW;
      default:   coef = '0;
    endcase
  endfunction

  function automatic logic [PW-1:0] sat_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[PW] ? '1 : s[PW-1:0];
  endfunction

endpackage

// File: rtl/scng_if.sv
interface scng_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        channel;
  logic [6:0]  bin;
  logic [47:0] capture_power;
  logic        saturated;

  modport source(output valid, kind, channel, bin, capture_power, saturated, input ready);
  modport sink(input valid, kind, channel, bin, capture_power, saturated, output ready);
endinterface

interface scng_result_if;
  logic               valid;
  logic               ready;
  logic               out_channel;
  logic [6:0]         out_bin;
  logic signed [25:0] noise_re;
  logic signed [25:0] noise_im;

  modport source(output valid, out_channel, out_bin, noise_re, noise_im, input ready);
  modport sink(input valid, out_channel, out_bin, noise_re, noise_im, output ready);
endinterface

// File: rtl/scng_ram.sv
module scng_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 130
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/scng_qmul.sv
// Serial multiplier: one coefficient bit per cycle, LSB first. The result is
// x*c/2^24 rounded half up and saturated to the power width.
module scng_qmul import scng_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] x,
  input  logic [CW-1:0] c,
  output logic          done,
  output logic [PW-1:0] p
);
  localparam int CNTW = $clog2(CW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   xr;
  logic [CW-1:0]   cr;
  logic [PW:0]     hi;
  logic [CW-1:0]   lo;
  logic [PW:0]     sum;
  logic [PW+1:0]   rnd;

  assign sum = hi + (cr[0] ? {1'b0, xr} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(CW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      xr  <= x;
      cr  <= c;
      hi  <= '0;
      lo  <= '0;
    end else if (busy) begin
      hi  <= {1'b0, sum[PW:1]};
      lo  <= {sum[0], lo[CW-1:1]};
      cr  <= cr >> 1;
      cnt <= cnt + 1'b1;
    end
  end

  // The product is {hi, lo}; bit 23 of it is the rounding bit.
  assign rnd = {hi, lo[CW-1]} + (PW+2)'(lo[CW-2]);
  assign p   = (rnd[PW+1:PW] != 2'b00) ? '1 : rnd[PW-1:0];
endmodule

// File: rtl/scng_isqrt.sv
// Digit-by-digit integer square root: two radicand bits enter per cycle and
// one root bit leaves; the result floor(sqrt(v)) is valid when done pulses.
module scng_isqrt import scng_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] v,
  output logic          done,
  output logic [MW-1:0] root
);
  localparam int CNTW = $clog2(MW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   vr;
  logic [MW:0]     rem;
  logic [MW+2:0]   rem_sh;
  logic [MW+2:0]   trial;

  assign rem_sh = {rem, vr[PW-1:PW-2]};
  assign trial  = {2'b00, root[MW-2:0], 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(MW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      vr   <= v;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      vr  <= vr << 2;
      cnt <= cnt + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= (MW+1)'(rem_sh - trial);
        root <= {root[MW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[MW:0];
        root <= {root[MW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/spectral_comfort_noise_generator.sv
// Comfort noise generator with a per-channel, per-bin noise power tracker.
// Input channel "item" carries requests: kind 0 feeds one capture power bin
// (no result), kind 1 asks for one noise bin (exactly one result on "result").
// The single noise floor register floor_r is written through cfg_we / cfg_wdata;
// the user must do so only while the block is idle; the block does not enforce it.
// Requests are taken only in the idle state, one at a time:
//   update: 2 to 6 products on the shared serial multiplier (one coefficient
//           bit per cycle), the last two only when the initial estimate is
//           blended; a saturated or out-of-range update is dropped in the
//           idle state without touching the state memories;
//   generate: runs the 24-step serial square root; a bin at a band edge or
//           out of range skips it and returns a zero result.
// After reset the three state memories are swept to their reset values, one
// entry per cycle over all CHANNELS*BINS entries; ready stays low during the sweep.
// A result waits in an output register; a new request is accepted while it
// waits, and a finished noise bin waits in the OUT state until the register
// frees up when the receiver stalls.
module spectral_comfort_noise_generator import scng_pkg::*; #(
  parameter int BINS     = 65,
  parameter int CHANNELS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [PW-1:0]  cfg_wdata,
  scng_item_if.sink      item,
  scng_result_if.source  result
);
  localparam int DEPTH = CHANNELS * BINS;
  localparam int AW    = $clog2(DEPTH);

  state_t  state, state_next;
  mul_op_t op;

  logic          item_fire, ch_ok, bin_ok, bin_edge, frame_start;
  logic [AW-1:0] idx_next, idx_r, clr_addr, waddr;
  logic          kind_r, ch_r, adapt_r;
  logic [6:0]    bin_r;
  logic [PW-1:0] y_r, sm_r, n2_r, ini_r, t_r, floor_r;
  logic [PW-1:0] sm_sum, n2_fl, x_mul, ini_fl;
  logic [PW-1:0] sm_rd, n2_rd, ini_rd, sm_wd, n2_wd, ini_wd;
  logic          ram_we, ini_we;
  logic [9:0]    frame_count;
  logic          initial_active;
  logic [SW-1:0] seed, seed_next;
  logic [47:0]   seed_prod;
  logic [4:0]    lcg_idx, tab_idx;
  logic          mul_start, mul_done, sqrt_start, sqrt_done;
  logic [PW-1:0] mul_p;
  logic [MW-1:0] mag;
  logic signed [15:0] tab_val;
  logic [14:0]   tab_abs;
  logic [38:0]   prod;
  logic [39:0]   prod_rnd;
  logic [OW-1:0] scaled;
  logic [OW-1:0] re_r, im_r;
  logic          res_valid, res_load;

  assign item_fire   = item.valid && item.ready;
  assign ch_ok       = 4'(item.channel) < 4'(CHANNELS);
  assign bin_ok      = 9'(item.bin) < 9'(BINS);
  assign bin_edge    = (item.bin == 7'd0) || (9'(item.bin) == 9'(BINS - 1));
  assign frame_start = !item.channel && (item.bin == 7'd0);
  assign idx_next    = AW'(item.bin) + (item.channel ? AW'(BINS) : '0);
  assign item.ready  = (state == S_IDLE);

  assign sm_sum = sat_add(t_r, mul_p);
  assign n2_fl  = (n2_r < floor_r) ? floor_r : n2_r;
  assign ini_fl = (ini_r < floor_r) ? floor_r : ini_r;

  always_comb begin
    case (op)
      OP_SM_OLD: x_mul = sm_r;
      OP_SM_NEW: x_mul = y_r;
      OP_N2_SM:  x_mul = sm_r;
      OP_IN_OLD: x_mul = ini_r;
      default:   x_mul = n2_r;
    endcase
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    ram_we     = 1'b0;
    ini_we     = 1'b0;
    res_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ini_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_fire) begin
          if (!item.kind) begin
            if (!item.saturated && ch_ok && bin_ok) begin
              state_next = S_READ;
            end
          end else if (ch_ok && bin_ok && !bin_edge) begin
            state_next = S_READ;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        if (kind_r) begin
          sqrt_start = 1'b1;
          state_next = S_SQRT_WAIT;
        end else begin
          state_next = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_SM_OLD: state_next = S_MUL_GO;
            OP_N2_SM:  state_next = S_MUL_GO;
            OP_IN_OLD: state_next = S_MUL_GO;
            OP_SM_NEW: state_next = adapt_r ? S_MUL_GO : S_FLOOR;
            OP_N2_OLD: state_next = S_FLOOR;
            OP_N2_UP:  state_next = S_FLOOR;
            OP_IN_NEW: state_next = S_IFLOOR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_FLOOR: begin
        if (initial_active && (n2_fl > ini_r)) begin
          state_next = S_MUL_GO;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_IFLOOR: state_next = S_WRITE;
      S_WRITE: begin
        ram_we     = 1'b1;
        ini_we     = initial_active;
        state_next = S_IDLE;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_next = S_SCALE_RE;
        end
      end
      S_SCALE_RE: state_next = S_SCALE_IM;
      S_SCALE_IM: state_next = S_OUT;
      S_OUT: begin
        if (!res_valid || result.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control state.
  assign seed_prod = seed * LCG_MUL;
  assign seed_next = seed_prod[SW-1:0] + 31'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      floor_r        <= FLOOR_RESET;
      frame_count    <= '0;
      initial_active <= 1'b1;
      seed           <= LCG_SEED_RESET;
      res_valid      <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        floor_r <= cfg_wdata;
      end
      if (item_fire && !item.kind && !item.saturated && ch_ok && bin_ok &&
          frame_start && initial_active) begin
        frame_count <= frame_count + 1'b1;
        if (frame_count + 1'b1 == INIT_FRAMES) begin
          initial_active <= 1'b0;
        end
      end
      if (state == S_LOAD && kind_r) begin
        seed <= seed_next;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      kind_r <= item.kind;
      ch_r   <= item.channel;
      bin_r  <= item.bin;
      y_r    <= item.capture_power;
      idx_r  <= idx_next;
      re_r   <= '0;
      im_r   <= '0;
      op     <= OP_SM_OLD;
      if (frame_start) begin
        adapt_r <= frame_count > FRAME_ADAPT;
      end else begin
        adapt_r <= !initial_active || (frame_count > FRAME_ADAPT_LATE);
      end
    end
    case (state)
      S_LOAD: begin
        sm_r    <= sm_rd;
        n2_r    <= n2_rd;
        ini_r   <= ini_rd;
        lcg_idx <= seed_next[SW-1:SW-5];
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_SM_OLD: begin
              t_r <= mul_p;
              op  <= OP_SM_NEW;
            end
            OP_SM_NEW: begin
              sm_r <= sm_sum;
              op   <= (sm_sum < n2_r) ? OP_N2_SM : OP_N2_UP;
            end
            OP_N2_SM: begin
              t_r <= mul_p;
              op  <= OP_N2_OLD;
            end
            OP_N2_OLD: n2_r <= sm_sum;
            OP_N2_UP:  n2_r <= mul_p;
            OP_IN_OLD: begin
              t_r <= mul_p;
              op  <= OP_IN_NEW;
            end
            OP_IN_NEW: ini_r <= sm_sum;
            default:   t_r <= mul_p;
          endcase
        end
      end
      S_FLOOR: begin
        n2_r <= n2_fl;
        op   <= OP_IN_OLD;
        if (!(n2_fl > ini_r)) begin
          ini_r <= n2_fl;
        end
      end
      S_IFLOOR:   ini_r <= ini_fl;
      S_SCALE_RE: re_r  <= scaled;
      S_SCALE_IM: im_r  <= scaled;
      default: ;
    endcase
  end

  // Random-phase scaling, real part then imaginary part on one multiplier.
  assign tab_idx  = (state == S_SCALE_RE) ? lcg_idx : lcg_idx + 5'd8;
  assign tab_val  = SIN_TAB[tab_idx];
  assign tab_abs  = tab_val[15] ? 15'(-tab_val) : tab_val[14:0];
  assign prod     = mag * tab_abs;
  assign prod_rnd = {1'b0, prod} + 40'd8192;
  assign scaled   = tab_val[15] ? OW'(-prod_rnd[39:14]) : prod_rnd[39:14];

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.out_channel <= ch_r;
      result.out_bin     <= bin_r;
      result.noise_re    <= re_r;
      result.noise_im    <= im_r;
    end
  end
  assign result.valid = res_valid;

  // State memories.
  assign waddr  = (state == S_CLEAR) ? clr_addr : idx_r;
  assign sm_wd  = (state == S_CLEAR) ? '0 : sm_r;
  assign n2_wd  = (state == S_CLEAR) ? NOISE_RESET : n2_r;
  assign ini_wd = (state == S_CLEAR) ? '0 : ini_r;

  scng_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_sm_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(sm_wd), .raddr(idx_r), .rdata(sm_rd)
  );
  scng_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_n2_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(n2_wd), .raddr(idx_r), .rdata(n2_rd)
  );
  scng_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ini_ram (
    .clk(clk), .we(ini_we), .waddr(waddr), .wdata(ini_wd), .raddr(idx_r), .rdata(ini_rd)
  );

  scng_qmul u_qmul (
    .clk(clk), .rst(rst), .start(mul_start), .x(x_mul), .c(coef(op)),
    .done(mul_done), .p(mul_p)
  );

  scng_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .v(initial_active ? ini_rd : n2_rd), .done(sqrt_done), .root(mag)
  );

`include "assert_macros.svh"
  `ASSERT_SAME(a_mul_done_wait, clk, rst, mul_done, state == S_MUL_WAIT, "product out of turn")
  `ASSERT_SAME(a_sqrt_done_wait, clk, rst, sqrt_done, state == S_SQRT_WAIT, "root out of turn")
  `ASSERT_SAME(a_init_end, clk, rst, !initial_active, frame_count == INIT_FRAMES,
               "initial phase ended at the wrong frame")
  `ASSERT_NEXT(a_out_hold, clk, rst, state == S_OUT && res_valid && !result.ready,
               state == S_OUT, "pending result overwritten")
endmodule
